/* rtl/ibt_pkg.sv */
package ibt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int COORD_BITS  = 20;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Result fields
  localparam int RES_W   = 7;
  localparam int STAT_W  = 2;
  localparam int RES_MAX = (1 << RES_W) - 1;

  // Command codes
  localparam logic CMD_BOOK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ORDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Request queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ITEM_BOOK,
    ITEM_QUERY,
    ITEM_BAD_ORDER
  } item_kind_e;

  typedef struct packed {
    item_kind_e             kind;
    logic [COORD_BITS-1:0]  lo;
    logic [COORD_BITS-1:0]  hi;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_FINISH
  } bk_state_e;

  // Clamp a table count to the result field width
  function automatic logic [RES_W-1:0] sat_count(input logic [CNT_W-1:0] v);
    logic [CNT_W+RES_W-1:0] wide;
    wide = (CNT_W + RES_W)'(v);
    if (wide > (CNT_W + RES_W)'(RES_MAX)) begin
      return RES_W'(RES_MAX);
    end
    return wide[RES_W-1:0];
  endfunction

endpackage

/* rtl/ibt_front.sv */
module ibt_front (
  input  logic                           start_i,
  input  logic                           command_i,
  input  logic [ibt_pkg::COORD_BITS-1:0] range_start_i,
  input  logic [ibt_pkg::COORD_BITS-1:0] range_end_i,
  input  ibt_pkg::queue_stat_t           q_stat_i,
  output logic                           busy_o,
  output logic                           push_o,
  output ibt_pkg::item_t                 item_o
);
  import ibt_pkg::*;

  // Stall the requester only when the queue has no room.
  assign busy_o = q_stat_i.full;
  assign push_o = start_i && !q_stat_i.full;

  // Classify the request before it reaches the table.
  always_comb begin
    item_o.lo = range_start_i;
    item_o.hi = range_end_i;
    if (command_i == CMD_QUERY) begin
      item_o.kind = ITEM_QUERY;
    end else if (range_start_i > range_end_i) begin
      item_o.kind = ITEM_BAD_ORDER;
    end else begin
      item_o.kind = ITEM_BOOK;
    end
  end

endmodule

/* rtl/ibt_queue.sv */
module ibt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ibt_pkg::item_t       item_i,
  input  logic                 pop_i,
  output ibt_pkg::item_t       item_o,
  output ibt_pkg::queue_stat_t stat_o
);
  import ibt_pkg::*;

  item_t               slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   fill_q, fill_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/ibt_back.sv */
module ibt_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ibt_pkg::queue_stat_t       q_stat_i,
  input  ibt_pkg::item_t             item_i,
  output logic                       pop_o,
  output logic                       done_o,
  output logic [ibt_pkg::RES_W-1:0]  result_count_o,
  output logic [ibt_pkg::STAT_W-1:0] status_o
);
  import ibt_pkg::*;

  bk_state_e                  state_q, state_d;
  item_t                      cur_q, cur_d;
  logic [IDX_W-1:0]           rd_idx_q, rd_idx_d;
  logic                       rd_on_q, rd_on_d;
  logic [IDX_W-1:0]           cmp_idx_q;
  logic                       cmp_on_q;
  logic [COORD_BITS-1:0]      rd_lo_q, rd_hi_q;
  logic [2*COORD_BITS-1:0]    mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]     valid_q, valid_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           hits_q, hits_d;
  logic [IDX_W-1:0]           slot_q, slot_d;
  logic                       slot_ok_q, slot_ok_d;
  logic                       done_q, done_d;
  logic [RES_W-1:0]           res_cnt_q, res_cnt_d;
  logic [STAT_W-1:0]          res_st_q, res_st_d;
  logic                       hit, free, last_cmp, mem_we;

  assign hit = cmp_on_q && valid_q[cmp_idx_q] &&
               (rd_lo_q <= cur_q.hi) && (rd_hi_q >= cur_q.lo);
  assign free     = cmp_on_q && (!valid_q[cmp_idx_q] || hit);
  assign last_cmp = cmp_on_q && (cmp_idx_q == IDX_W'(TABLE_DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty && item_i.kind == ITEM_BOOK) begin
          state_d = BK_SWEEP;
        end
      end
      BK_SWEEP: begin
        if (last_cmp) begin
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // Datapath and results
  always_comb begin
    pop_o     = 1'b0;
    cur_d     = cur_q;
    rd_idx_d  = rd_idx_q;
    rd_on_d   = rd_on_q;
    valid_d   = valid_q;
    count_d   = count_q;
    hits_d    = hits_q;
    slot_d    = slot_q;
    slot_ok_d = slot_ok_q;
    done_d    = 1'b0;
    res_cnt_d = res_cnt_q;
    res_st_d  = res_st_q;
    mem_we    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          cur_d = item_i;
          case (item_i.kind)
            ITEM_QUERY: begin
              done_d    = 1'b1;
              res_cnt_d = sat_count(count_q);
              res_st_d  = ST_OK;
            end
            ITEM_BAD_ORDER: begin
              done_d    = 1'b1;
              res_cnt_d = '0;
              res_st_d  = ST_ORDER;
            end
            default: begin
              rd_idx_d  = '0;
              rd_on_d   = 1'b1;
              hits_d    = '0;
              slot_ok_d = 1'b0;
            end
          endcase
        end
      end
      BK_SWEEP: begin
        if (rd_on_q) begin
          if (rd_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
            rd_on_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        // Evict on overlap; remember the first free entry.
        if (hit) begin
          valid_d[cmp_idx_q] = 1'b0;
          hits_d             = hits_q + 1'b1;
        end
        if (free && !slot_ok_q) begin
          slot_d    = cmp_idx_q;
          slot_ok_d = 1'b1;
        end
      end
      BK_FINISH: begin
        done_d = 1'b1;
        if (slot_ok_q) begin
          mem_we          = 1'b1;
          valid_d[slot_q] = 1'b1;
          count_d         = count_q - hits_q + 1'b1;
          res_cnt_d       = sat_count(hits_q);
          res_st_d        = ST_OK;
        end else begin
          res_cnt_d = '0;
          res_st_d  = ST_FULL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      rd_on_q   <= 1'b0;
      cmp_on_q  <= 1'b0;
      valid_q   <= '0;
      count_q   <= '0;
      slot_ok_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_on_q   <= rd_on_d;
      cmp_on_q  <= rd_on_q;
      valid_q   <= valid_d;
      count_q   <= count_d;
      slot_ok_q <= slot_ok_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= rd_idx_q;
    hits_q    <= hits_d;
    slot_q    <= slot_d;
    res_cnt_q <= res_cnt_d;
    res_st_q  <= res_st_d;
  end

  // Interval memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= {cur_q.lo, cur_q.hi};
    end
    if (rd_on_q) begin
      {rd_lo_q, rd_hi_q} <= mem_q[rd_idx_q];
    end
  end

  assign done_o         = done_q;
  assign result_count_o = res_cnt_q;
  assign status_o       = res_st_q;

endmodule

/* rtl/interval_booking_table_top.sv */
// Interval booking table: a set of pairwise disjoint closed intervals.
//
// Request channel: drive command_i, range_start_i, range_end_i and raise
// start_i; the request is taken at a rising edge where start_i is high and
// busy_o is low. A book request (command 0) evicts every stored interval
// that touches [start,end], stores the new one in the lowest free entry and
// reports the number evicted. A query request (command 1) reports the number
// of stored intervals.
// Result channel: done_o pulses for one cycle with result_count_o and
// status_o (0 ok, 1 start after end, 2 table full). There is no back
// pressure; the receiver must take the result in that cycle.
// Queueing and rate: a two-entry request queue sits in front of the table
// engine, so up to two requests can wait. A query or a rejected-order
// request is answered as it is popped, and its result is registered onto
// done_o. A book request walks the interval memory one entry per cycle
// through its single read port, and that sweep sets the sustained rate;
// the engine pops no new request until the book request is finished.
// Reset: clears the valid bits and the count at once, so the table is empty
// and the queue drained; no clearing pass is needed.
module interval_booking_table_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           command_i,
  input  logic [ibt_pkg::COORD_BITS-1:0] range_start_i,
  input  logic [ibt_pkg::COORD_BITS-1:0] range_end_i,
  output logic                           done_o,
  output logic [ibt_pkg::RES_W-1:0]      result_count_o,
  output logic [ibt_pkg::STAT_W-1:0]     status_o
);
  import ibt_pkg::*;

  // Front to queue
  logic        push;
  item_t       push_item;
  // Queue to engine
  logic        pop;
  item_t       head_item;
  queue_stat_t q_stat;

  // Classify requests and hold off the requester when the queue is full.
  ibt_front u_front (
    .start_i       (start_i),
    .command_i     (command_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .q_stat_i      (q_stat),
    .busy_o        (busy_o),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Decouple acceptance from the table sweep.
  ibt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // Sweep, evict, insert and report.
  ibt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .item_i         (head_item),
    .pop_o          (pop),
    .done_o         (done_o),
    .result_count_o (result_count_o),
    .status_o       (status_o)
  );

endmodule

/* rtl/ibt_checker.sv */
module ibt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           command_i,
  input logic [ibt_pkg::COORD_BITS-1:0] range_start_i,
  input logic [ibt_pkg::COORD_BITS-1:0] range_end_i,
  input logic                           done_o,
  input logic [ibt_pkg::RES_W-1:0]      result_count_o,
  input logic [ibt_pkg::STAT_W-1:0]     status_o
);
  import ibt_pkg::*;

  logic [3:0] pend_q;
  logic       acc;

  assign acc = start_i && !busy_o;

  // Count requests taken but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (acc && !done_o) begin
      pend_q <= pend_q + 1'b1;
    end else if (done_o && !acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pend_q != '0)
    else $error("result without an outstanding request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_ORDER || status_o == ST_FULL))
    else $error("undefined status code");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> result_count_o == '0)
    else $error("rejected request reports a nonzero count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (RES_W + 13)'(result_count_o) <= (RES_W + 13)'(TABLE_DEPTH))
    else $error("count exceeds table depth");

  a_busy_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q > 4'(QUEUE_DEPTH + 1)) |-> busy_o)
    else $error("requests accepted beyond queue and engine capacity");

endmodule

bind interval_booking_table_top ibt_checker u_ibt_checker (.*);
